/* rtl/core/pebc_pkg.sv */
// Shared types, constants and command codes for the pause-excise burst coalescer.
`default_nettype none
package pebc_pkg;

    localparam int MAX_PAUSES = 16;
    localparam int TIME_BITS  = 40;
    localparam int PIDX_BITS  = (MAX_PAUSES > 1) ? $clog2(MAX_PAUSES) : 1;
    localparam int CNT_BITS   = $clog2(MAX_PAUSES + 1);
    localparam int SHIFT_BITS = TIME_BITS + CNT_BITS;
    localparam int KEY_BITS   = 8;
    localparam int GAP_BITS   = 16;
    localparam int CFG_BITS   = 16;
    localparam int REG_BITS   = 2;

    localparam logic [GAP_BITS-1:0] MERGE_GAP_RST = 16'd1500;
    localparam logic [GAP_BITS-1:0] TAIL_PAD_RST  = 16'd600;
    localparam logic [KEY_BITS-1:0] MIN_KEYS_RST  = 8'd3;
    localparam logic [KEY_BITS-1:0] KEY_MAX       = 8'd255;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef enum logic [REG_BITS-1:0] {
        REG_MERGE_GAP = 2'd0,
        REG_TAIL_PAD  = 2'd1,
        REG_MIN_KEYS  = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [TIME_BITS-1:0] event_time_ms;
        logic [TIME_BITS-1:0] range_start_ms;
        logic [TIME_BITS-1:0] range_end_ms;
    } in_beat_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] burst_start_ms;
        logic [TIME_BITS:0]   burst_end_ms;
    } out_beat_t;

    typedef struct packed {
        logic [GAP_BITS-1:0] merge_gap;
        logic [GAP_BITS-1:0] tail_pad;
        logic [KEY_BITS-1:0] min_keys;
    } cfg_t;

    // token moving down the range chain
    typedef struct packed {
        logic                  valid;
        cmd_t                  cmd;
        logic                  add_ok;
        logic [PIDX_BITS-1:0]  slot;
        logic [TIME_BITS-1:0]  t;
        logic [TIME_BITS-1:0]  rs;
        logic [TIME_BITS-1:0]  re;
        logic                  drop;
        logic [SHIFT_BITS-1:0] shift;
    } chain_t;

endpackage
`default_nettype wire

/* rtl/core/pebc_cell.sv */
// One pause-range cell: holds a range and applies it to each passing token.
`default_nettype none
module pebc_cell
    import pebc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire logic [PIDX_BITS-1:0] cell_idx,
    input  wire chain_t               tok_i,
    output chain_t                    tok_o
);

    logic                 used_reg, used_next;
    logic [TIME_BITS-1:0] start_reg, end_reg;
    logic                 capture;
    logic                 hit, past;
    logic [TIME_BITS-1:0] len;
    chain_t               tok_reg, tok_next;

    assign capture = tok_i.valid && (tok_i.cmd == CMD_ADD) && tok_i.add_ok
                     && (tok_i.slot == cell_idx);
    assign hit  = used_reg && (tok_i.t >= start_reg) && (tok_i.t < end_reg);
    assign past = used_reg && (tok_i.t >= end_reg);
    assign len  = end_reg - start_reg;

    always_comb begin
        used_next = used_reg;
        tok_next  = tok_i;
        if (tok_i.valid) begin
            if (tok_i.cmd == CMD_CLEAR) begin
                used_next = 1'b0;
            end else if (capture) begin
                used_next = 1'b1;
            end
            if (tok_i.cmd == CMD_EVENT) begin
                tok_next.drop = tok_i.drop | hit;
                if (past) begin
                    tok_next.shift = tok_i.shift + SHIFT_BITS'(len);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (advance) begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && capture) begin
            start_reg <= tok_i.rs;
            end_reg   <= tok_i.re;
        end
    end

    assign tok_o = tok_reg;

endmodule
`default_nettype wire

/* rtl/core/pebc_burst.sv */
// Time adjust stage, gap-based burst coalescer and output register.
`default_nettype none
module pebc_burst
    import pebc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire cfg_t      cfg,
    input  wire chain_t    tok_i,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    // adjust stage
    logic                 adj_valid_reg;
    cmd_t                 adj_cmd_reg;
    logic [TIME_BITS-1:0] adj_reg, adj_next;
    logic                 take;

    // burst state
    logic                 open_reg, open_next;
    logic [TIME_BITS-1:0] first_reg, first_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [KEY_BITS-1:0]  cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    out_beat_t            out_reg, out_next;
    logic                 emit;
    logic                 emit_ok;
    logic                 extend;
    logic [TIME_BITS-1:0] gap;

    assign take = tok_i.valid && ((tok_i.cmd == CMD_FLUSH) ||
                  ((tok_i.cmd == CMD_EVENT) && !tok_i.drop));

    always_comb begin
        if ({{CNT_BITS{1'b0}}, tok_i.t} > tok_i.shift) begin
            adj_next = tok_i.t - tok_i.shift[TIME_BITS-1:0];
        end else begin
            adj_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adj_valid_reg <= 1'b0;
        end else if (advance) begin
            adj_valid_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            adj_cmd_reg <= tok_i.cmd;
            adj_reg     <= adj_next;
        end
    end

    assign gap     = adj_reg - last_reg;
    assign extend  = (adj_reg < last_reg) || (gap <= TIME_BITS'(cfg.merge_gap));
    assign emit_ok = open_reg && (cnt_reg >= cfg.min_keys);

    always_comb begin
        open_next  = open_reg;
        first_next = first_reg;
        last_next  = last_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        if (adj_valid_reg) begin
            if (adj_cmd_reg == CMD_FLUSH) begin
                emit       = emit_ok;
                open_next  = 1'b0;
                first_next = '0;
                last_next  = '0;
                cnt_next   = '0;
            end else if (!open_reg) begin
                open_next  = 1'b1;
                first_next = adj_reg;
                last_next  = adj_reg;
                cnt_next   = KEY_BITS'(1);
            end else if (extend) begin
                last_next = adj_reg;
                if (cnt_reg != KEY_MAX) begin
                    cnt_next = cnt_reg + KEY_BITS'(1);
                end
            end else begin
                emit       = emit_ok;
                first_next = adj_reg;
                last_next  = adj_reg;
                cnt_next   = KEY_BITS'(1);
            end
        end
    end

    always_comb begin
        out_next.burst_start_ms = first_reg;
        out_next.burst_end_ms   = {1'b0, last_reg} + (TIME_BITS + 1)'(cfg.tail_pad);
        if (advance) begin
            out_valid_next = emit;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg      <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                open_reg  <= open_next;
                first_reg <= first_next;
                last_reg  <= last_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_open_count: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (cnt_reg != '0))
        else $error("open burst with zero count");
    a_closed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !open_reg |-> (cnt_reg == '0) && (last_reg == '0))
        else $error("closed burst holds stale state");
    a_emit_needs_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && emit) |-> open_reg && adj_valid_reg)
        else $error("burst emitted without an open burst");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("result lost while stalled");
`endif

endmodule
`default_nettype wire

/* rtl/core/pause_excise_burst_coalesce_core.sv */
// Top level: pause-range cell chain feeding the burst coalescer.
`default_nettype none
// One beat is accepted per cycle unless the result register is full and stalled.
// Each beat walks the chain of MAX_PAUSES range cells, then a registered adjust
// stage and the burst stage, whose output register holds the result of the event
// or flush beat that closed a burst. Range adds and clears travel down the same
// chain, so every event sees exactly the ranges loaded before it. Configuration
// writes must be made while the block is idle; the block does not enforce this.
module pause_excise_burst_coalesce_core
    import pebc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [REG_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0] cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_beat_t            s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_beat_t                m_data
);

    cfg_t                cfg_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                advance;
    logic                accept;
    logic                add_ok;
    chain_t              link [0:MAX_PAUSES];

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;
    assign add_ok  = (count_reg < CNT_BITS'(MAX_PAUSES))
                     && (s_data.range_end_ms > s_data.range_start_ms);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.merge_gap <= MERGE_GAP_RST;
            cfg_reg.tail_pad  <= TAIL_PAD_RST;
            cfg_reg.min_keys  <= MIN_KEYS_RST;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MERGE_GAP: cfg_reg.merge_gap <= cfg_wdata;
                REG_TAIL_PAD:  cfg_reg.tail_pad  <= cfg_wdata;
                REG_MIN_KEYS:  cfg_reg.min_keys  <= cfg_wdata[KEY_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (cmd_t'(s_data.cmd) == CMD_CLEAR) begin
                count_next = '0;
            end else if ((cmd_t'(s_data.cmd) == CMD_ADD) && add_ok) begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_comb begin
        link[0].valid  = accept;
        link[0].cmd    = cmd_t'(s_data.cmd);
        link[0].add_ok = add_ok;
        link[0].slot   = count_reg[PIDX_BITS-1:0];
        link[0].t      = s_data.event_time_ms;
        link[0].rs     = s_data.range_start_ms;
        link[0].re     = s_data.range_end_ms;
        link[0].drop   = 1'b0;
        link[0].shift  = '0;
    end

    for (genvar i = 0; i < MAX_PAUSES; i++) begin : g_cell
        pebc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_idx (PIDX_BITS'(i)),
            .tok_i    (link[i]),
            .tok_o    (link[i+1])
        );
    end

    pebc_burst u_burst (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg_reg),
        .tok_i   (link[MAX_PAUSES]),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_PAUSES))
        else $error("pause count above table size");
    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd_t'(s_data.cmd) == CMD_CLEAR)) |=> (count_reg == '0))
        else $error("clear did not empty the table");
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(count_reg))
        else $error("table count moved while stalled");
`endif

endmodule
`default_nettype wire
